FILE: hdl/cpbe_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and encoding functions for the code point to byte encoder.
package cpbe_pkg;

    localparam int CP_W       = 21;
    localparam int HELD_W     = 10;
    localparam int MAX_BYTES  = 7;
    localparam int CNT_W      = 3;

    localparam logic [7:0] SUB_CHAR = 8'h2e;

    typedef enum logic [1:0] {
        ENC_ISO8859 = 2'd0,
        ENC_UTF8    = 2'd1,
        ENC_UTF16BE = 2'd2,
        ENC_CP437   = 2'd3
    } enc_t;

    typedef enum logic {
        CFG_OUTPUT_ENCODING  = 1'b0,
        CFG_COMBINE_SURROGATES = 1'b1
    } cfg_idx_t;

    // Bytes for one code point
    typedef struct packed {
        logic [3:0][7:0] b;
        logic [2:0]      cnt;
    } pt_bytes_t;

    // Bytes for one input transaction plus the next surrogate hold state
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [CNT_W-1:0]          cnt;
        logic                      held_valid;
        logic [HELD_W-1:0]         held_bits;
    } enc_result_t;

    function automatic logic [7:0] cp437_lookup(input logic [13:0] cp);
        logic [7:0] r;
        r = SUB_CHAR;
        case (cp)
            14'h263a: r = 8'h01;  14'h263b: r = 8'h02;  14'h2665: r = 8'h03;
            14'h2666: r = 8'h04;  14'h2663: r = 8'h05;  14'h2660: r = 8'h06;
            14'h2022: r = 8'h07;
            14'h25d8: r = 8'h08;  14'h25cb: r = 8'h09;  14'h25d9: r = 8'h0a;
            14'h2642: r = 8'h0b;  14'h2640: r = 8'h0c;  14'h266a: r = 8'h0d;
            14'h263c: r = 8'h0f;
            14'h25ba: r = 8'h10;  14'h25c4: r = 8'h11;  14'h2195: r = 8'h12;
            14'h203c: r = 8'h13;  14'h00b6: r = 8'h14;  14'h00a7: r = 8'h15;
            14'h25ac: r = 8'h16;  14'h21a8: r = 8'h17;
            14'h2191: r = 8'h18;  14'h2193: r = 8'h19;  14'h2192: r = 8'h1a;
            14'h2190: r = 8'h1b;  14'h221f: r = 8'h1c;  14'h2194: r = 8'h1d;
            14'h25b2: r = 8'h1e;  14'h25bc: r = 8'h1f;
            14'h2302: r = 8'h7f;
            14'h00c7: r = 8'h80;  14'h00fc: r = 8'h81;  14'h00e9: r = 8'h82;
            14'h00e2: r = 8'h83;  14'h00e4: r = 8'h84;  14'h00e0: r = 8'h85;
            14'h00e5: r = 8'h86;  14'h00e7: r = 8'h87;
            14'h00ea: r = 8'h88;  14'h00eb: r = 8'h89;  14'h00e8: r = 8'h8a;
            14'h00ef: r = 8'h8b;  14'h00ee: r = 8'h8c;  14'h00ec: r = 8'h8d;
            14'h00c4: r = 8'h8e;  14'h00c5: r = 8'h8f;
            14'h00c9: r = 8'h90;  14'h00e6: r = 8'h91;  14'h00c6: r = 8'h92;
            14'h00f4: r = 8'h93;  14'h00f6: r = 8'h94;  14'h00f2: r = 8'h95;
            14'h00fb: r = 8'h96;  14'h00f9: r = 8'h97;
            14'h00ff: r = 8'h98;  14'h00d6: r = 8'h99;  14'h00dc: r = 8'h9a;
            14'h00a2: r = 8'h9b;  14'h00a3: r = 8'h9c;  14'h00a5: r = 8'h9d;
            14'h20a7: r = 8'h9e;  14'h0192: r = 8'h9f;
            14'h00e1: r = 8'ha0;  14'h00ed: r = 8'ha1;  14'h00f3: r = 8'ha2;
            14'h00fa: r = 8'ha3;  14'h00f1: r = 8'ha4;  14'h00d1: r = 8'ha5;
            14'h00aa: r = 8'ha6;  14'h00ba: r = 8'ha7;
            14'h00bf: r = 8'ha8;  14'h2310: r = 8'ha9;  14'h00ac: r = 8'haa;
            14'h00bd: r = 8'hab;  14'h00bc: r = 8'hac;  14'h00a1: r = 8'had;
            14'h00ab: r = 8'hae;  14'h00bb: r = 8'haf;
            14'h2591: r = 8'hb0;  14'h2592: r = 8'hb1;  14'h2593: r = 8'hb2;
            14'h2502: r = 8'hb3;  14'h2524: r = 8'hb4;  14'h2561: r = 8'hb5;
            14'h2562: r = 8'hb6;  14'h2556: r = 8'hb7;
            14'h2555: r = 8'hb8;  14'h2563: r = 8'hb9;  14'h2551: r = 8'hba;
            14'h2557: r = 8'hbb;  14'h255d: r = 8'hbc;  14'h255c: r = 8'hbd;
            14'h255b: r = 8'hbe;  14'h2510: r = 8'hbf;
            14'h2514: r = 8'hc0;  14'h2534: r = 8'hc1;  14'h252c: r = 8'hc2;
            14'h251c: r = 8'hc3;  14'h2500: r = 8'hc4;  14'h253c: r = 8'hc5;
            14'h255e: r = 8'hc6;  14'h255f: r = 8'hc7;
            14'h255a: r = 8'hc8;  14'h2554: r = 8'hc9;  14'h2569: r = 8'hca;
            14'h2566: r = 8'hcb;  14'h2560: r = 8'hcc;  14'h2550: r = 8'hcd;
            14'h256c: r = 8'hce;  14'h2567: r = 8'hcf;
            14'h2568: r = 8'hd0;  14'h2564: r = 8'hd1;  14'h2565: r = 8'hd2;
            14'h2559: r = 8'hd3;  14'h2558: r = 8'hd4;  14'h2552: r = 8'hd5;
            14'h2553: r = 8'hd6;  14'h256b: r = 8'hd7;
            14'h256a: r = 8'hd8;  14'h2518: r = 8'hd9;  14'h250c: r = 8'hda;
            14'h2588: r = 8'hdb;  14'h2584: r = 8'hdc;  14'h258c: r = 8'hdd;
            14'h2590: r = 8'hde;  14'h2580: r = 8'hdf;
            14'h03b1: r = 8'he0;  14'h00df: r = 8'he1;  14'h0393: r = 8'he2;
            14'h03c0: r = 8'he3;  14'h03a3: r = 8'he4;  14'h03c3: r = 8'he5;
            14'h00b5: r = 8'he6;  14'h03c4: r = 8'he7;
            14'h03a6: r = 8'he8;  14'h0398: r = 8'he9;  14'h03a9: r = 8'hea;
            14'h03b4: r = 8'heb;  14'h221e: r = 8'hec;  14'h03c6: r = 8'hed;
            14'h03b5: r = 8'hee;  14'h2229: r = 8'hef;
            14'h2261: r = 8'hf0;  14'h00b1: r = 8'hf1;  14'h2265: r = 8'hf2;
            14'h2264: r = 8'hf3;  14'h2320: r = 8'hf4;  14'h2321: r = 8'hf5;
            14'h00f7: r = 8'hf6;  14'h2248: r = 8'hf7;
            14'h00b0: r = 8'hf8;  14'h2219: r = 8'hf9;  14'h00b7: r = 8'hfa;
            14'h221a: r = 8'hfb;  14'h207f: r = 8'hfc;  14'h00b2: r = 8'hfd;
            14'h25a0: r = 8'hfe;  14'h00a0: r = 8'hff;
            default: r = SUB_CHAR;
        endcase
        return r;
    endfunction

    function automatic pt_bytes_t encode_point(input enc_t enc, input logic [CP_W-1:0] cp);
        pt_bytes_t        p;
        logic [CP_W-1:0]  v;
        logic [15:0]      hi;
        logic [15:0]      lo;
        p.b   = '0;
        p.cnt = 3'd1;
        v     = cp - 21'h10000;
        hi    = 16'hd800 | {5'b0, v[20:10]};
        lo    = 16'hdc00 | {6'b0, v[9:0]};
        case (enc)
            ENC_ISO8859:
            begin
                p.b[0] = (cp <= 21'hff) ? cp[7:0] : SUB_CHAR;
            end
            ENC_UTF8:
            begin
                if (cp < 21'h80)
                begin
                    p.b[0] = cp[7:0];
                end
                else if (cp < 21'h800)
                begin
                    p.cnt  = 3'd2;
                    p.b[0] = {3'b110, cp[10:6]};
                    p.b[1] = {2'b10, cp[5:0]};
                end
                else if (cp < 21'h10000)
                begin
                    p.cnt  = 3'd3;
                    p.b[0] = {4'b1110, cp[15:12]};
                    p.b[1] = {2'b10, cp[11:6]};
                    p.b[2] = {2'b10, cp[5:0]};
                end
                else
                begin
                    p.cnt  = 3'd4;
                    p.b[0] = {5'b11110, cp[20:18]};
                    p.b[1] = {2'b10, cp[17:12]};
                    p.b[2] = {2'b10, cp[11:6]};
                    p.b[3] = {2'b10, cp[5:0]};
                end
            end
            ENC_UTF16BE:
            begin
                if (cp < 21'h10000)
                begin
                    p.cnt  = 3'd2;
                    p.b[0] = cp[15:8];
                    p.b[1] = cp[7:0];
                end
                else
                begin
                    p.cnt  = 3'd4;
                    p.b[0] = hi[15:8];
                    p.b[1] = hi[7:0];
                    p.b[2] = lo[15:8];
                    p.b[3] = lo[7:0];
                end
            end
            default:
            begin
                if (cp < 21'h80)
                begin
                    p.b[0] = cp[7:0];
                end
                else if (cp < 21'h266b)
                begin
                    p.b[0] = cp437_lookup(cp[13:0]);
                end
                else
                begin
                    p.b[0] = SUB_CHAR;
                end
            end
        endcase
        return p;
    endfunction

endpackage

FILE: hdl/cpbe_encode.sv
`timescale 1ns / 1ps
// Combinational encoder: surrogate resolution and byte run for one transaction.
module cpbe_encode (
    input  logic [20:0]           code_unit,
    input  logic                  end_of_text,
    input  cpbe_pkg::enc_t        enc,
    input  logic                  combine,
    input  logic                  held_valid,
    input  logic [9:0]            held_bits,
    output cpbe_pkg::enc_result_t result
);
    import cpbe_pkg::*;

    logic            is_low;
    logic            is_high;
    logic            orphan;
    logic            hold;
    logic [CP_W-1:0] orphan_cp;
    logic [CP_W-1:0] main_cp;
    pt_bytes_t       p1;
    pt_bytes_t       p2;
    logic [CNT_W-1:0] c1;
    logic [CNT_W-1:0] c2;
    logic [CNT_W-1:0] j;

    assign is_low    = (code_unit >= 21'hdc00) && (code_unit < 21'he000);
    assign is_high   = (code_unit >= 21'hd800) && (code_unit < 21'hdc00);
    assign orphan    = held_valid && !is_low;
    assign hold      = !(held_valid && is_low) && combine && !end_of_text && is_high;
    assign orphan_cp = {11'b0, held_bits} | 21'hd800;
    assign main_cp   = (held_valid && is_low)
                       ? 21'h10000 + {1'b0, held_bits, code_unit[9:0]}
                       : code_unit;
    assign p1        = encode_point(enc, orphan_cp);
    assign p2        = encode_point(enc, main_cp);
    assign c1        = orphan ? p1.cnt : '0;
    assign c2        = hold ? '0 : p2.cnt;

    always_comb
    begin
        result.cnt        = c1 + c2;
        result.held_valid = hold;
        result.held_bits  = hold ? code_unit[9:0] : held_bits;
        for (int i = 0; i < MAX_BYTES; i++)
        begin
            j = CNT_W'(i) - c1;
            if (CNT_W'(i) < c1)
            begin
                result.bytes[i] = p1.b[i % 4];
            end
            else
            begin
                result.bytes[i] = p2.b[j[1:0]];
            end
        end
    end

endmodule

FILE: hdl/code_point_to_byte_encoder_core.sv
`timescale 1ns / 1ps
// Top level of the code point to byte encoder: config, run buffer and output register.
//
//  channel | handshake          | payload
//  --------+--------------------+--------------------------------
//  in      | in_valid/in_stall  | code_unit[20:0], end_of_text
//  out     | out_valid/out_stall| out_byte[7:0], run_end
//  cfg     | cfg_we             | cfg_index, cfg_data[1:0]
//
// An input transaction is encoded in the cycle it is accepted into a run buffer
// of up to 7 bytes; the buffer drains one byte per cycle into the output register
// unless out_stall holds it. A transaction keeps the buffer until its last byte leaves;
// the next one is taken in the cycle the last byte leaves, so input and output overlap.
// A held high surrogate produces no bytes and frees the input at once.
// Reset: UTF-8 output, surrogate combining on, nothing held, buffers empty.
module code_point_to_byte_encoder_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [1:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [20:0] code_unit,
    input  logic        end_of_text,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        run_end
);
    import cpbe_pkg::*;

    enc_t                      enc_reg;
    logic                      combine_reg;
    logic                      held_valid_reg;
    logic [HELD_W-1:0]         held_bits_reg;
    logic                      buf_valid_reg;
    logic [MAX_BYTES-1:0][7:0] buf_bytes_reg;
    logic [CNT_W-1:0]          buf_cnt_reg;
    logic [CNT_W-1:0]          buf_idx_reg;
    logic                      out_valid_reg;
    logic [7:0]                out_byte_reg;
    logic                      run_end_reg;

    enc_result_t result;
    logic        in_accept;
    logic        buf_move;
    logic        buf_last;
    logic        buf_valid_next;

    cpbe_encode u_encode (
        .code_unit   (code_unit),
        .end_of_text (end_of_text),
        .enc         (enc_reg),
        .combine     (combine_reg),
        .held_valid  (held_valid_reg),
        .held_bits   (held_bits_reg),
        .result      (result)
    );

    assign buf_move  = buf_valid_reg && (!out_valid_reg || !out_stall);
    assign buf_last  = (buf_idx_reg == buf_cnt_reg - 3'd1);
    assign in_stall  = buf_valid_reg && !(buf_move && buf_last);
    assign in_accept = in_valid && !in_stall;
    assign buf_valid_next = in_accept ? (result.cnt != '0)
                                      : (buf_valid_reg && !(buf_move && buf_last));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enc_reg     <= ENC_UTF8;
            combine_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_OUTPUT_ENCODING:    enc_reg     <= enc_t'(cfg_data);
                CFG_COMBINE_SURROGATES: combine_reg <= cfg_data[0];
                default:                combine_reg <= combine_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
            held_bits_reg  <= '0;
            buf_valid_reg  <= 1'b0;
            buf_idx_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            buf_valid_reg <= buf_valid_next;
            if (in_accept)
            begin
                held_valid_reg <= result.held_valid;
                held_bits_reg  <= result.held_bits;
                buf_idx_reg    <= '0;
            end
            else if (buf_move)
            begin
                buf_idx_reg <= buf_idx_reg + 3'd1;
            end
            if (buf_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            buf_bytes_reg <= result.bytes;
            buf_cnt_reg   <= result.cnt;
        end
        if (buf_move)
        begin
            out_byte_reg <= buf_bytes_reg[buf_idx_reg];
            run_end_reg  <= buf_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign run_end   = run_end_reg;

    a_buf_index: assert property (@(posedge clk) disable iff (!rst_n)
        buf_valid_reg |-> (buf_cnt_reg != '0) && (buf_idx_reg < buf_cnt_reg))
        else $error("run buffer index out of range");

    a_accept_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && buf_valid_reg) |-> (buf_move && buf_last))
        else $error("transaction accepted over a busy run buffer");

    a_hold_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(held_valid_reg) |-> $past(in_valid && !in_stall))
        else $error("surrogate hold set without a transaction");

    a_last_byte_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (buf_move && buf_last) |=> (out_valid_reg && run_end_reg))
        else $error("last byte of run not flagged");

endmodule

FILE: bench/tb_code_point_to_byte_encoder_core.sv
`timescale 1ns / 1ps
// Self-checking bench for the code point to byte encoder: random text in every encoding, byte-level checks.
module tb_code_point_to_byte_encoder_core;
    import cpbe_pkg::*;

    localparam int SETTLE_CYC  = 10;
    localparam int STALL_LIMIT = 2000;

    typedef enum logic [1:0] {
        ACT_UNIT,
        ACT_CFG,
        ACT_DRAIN
    } act_kind_t;

    typedef struct {
        act_kind_t   kind;
        logic [20:0] cu;
        logic        eot;
        cfg_idx_t    reg_sel;
        logic [1:0]  reg_val;
    } text_act_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } byte_exp_t;

    localparam logic [15:0] CP437_GLYPH [256] = '{
        16'h0000, 16'h263a, 16'h263b, 16'h2665, 16'h2666, 16'h2663, 16'h2660, 16'h2022,
        16'h25d8, 16'h25cb, 16'h25d9, 16'h2642, 16'h2640, 16'h266a, 16'h266b, 16'h263c,
        16'h25ba, 16'h25c4, 16'h2195, 16'h203c, 16'h00b6, 16'h00a7, 16'h25ac, 16'h21a8,
        16'h2191, 16'h2193, 16'h2192, 16'h2190, 16'h221f, 16'h2194, 16'h25b2, 16'h25bc,
        16'h0020, 16'h0021, 16'h0022, 16'h0023, 16'h0024, 16'h0025, 16'h0026, 16'h0027,
        16'h0028, 16'h0029, 16'h002a, 16'h002b, 16'h002c, 16'h002d, 16'h002e, 16'h002f,
        16'h0030, 16'h0031, 16'h0032, 16'h0033, 16'h0034, 16'h0035, 16'h0036, 16'h0037,
        16'h0038, 16'h0039, 16'h003a, 16'h003b, 16'h003c, 16'h003d, 16'h003e, 16'h003f,
        16'h0040, 16'h0041, 16'h0042, 16'h0043, 16'h0044, 16'h0045, 16'h0046, 16'h0047,
        16'h0048, 16'h0049, 16'h004a, 16'h004b, 16'h004c, 16'h004d, 16'h004e, 16'h004f,
        16'h0050, 16'h0051, 16'h0052, 16'h0053, 16'h0054, 16'h0055, 16'h0056, 16'h0057,
        16'h0058, 16'h0059, 16'h005a, 16'h005b, 16'h005c, 16'h005d, 16'h005e, 16'h005f,
        16'h0060, 16'h0061, 16'h0062, 16'h0063, 16'h0064, 16'h0065, 16'h0066, 16'h0067,
        16'h0068, 16'h0069, 16'h006a, 16'h006b, 16'h006c, 16'h006d, 16'h006e, 16'h006f,
        16'h0070, 16'h0071, 16'h0072, 16'h0073, 16'h0074, 16'h0075, 16'h0076, 16'h0077,
        16'h0078, 16'h0079, 16'h007a, 16'h007b, 16'h007c, 16'h007d, 16'h007e, 16'h2302,
        16'h00c7, 16'h00fc, 16'h00e9, 16'h00e2, 16'h00e4, 16'h00e0, 16'h00e5, 16'h00e7,
        16'h00ea, 16'h00eb, 16'h00e8, 16'h00ef, 16'h00ee, 16'h00ec, 16'h00c4, 16'h00c5,
        16'h00c9, 16'h00e6, 16'h00c6, 16'h00f4, 16'h00f6, 16'h00f2, 16'h00fb, 16'h00f9,
        16'h00ff, 16'h00d6, 16'h00dc, 16'h00a2, 16'h00a3, 16'h00a5, 16'h20a7, 16'h0192,
        16'h00e1, 16'h00ed, 16'h00f3, 16'h00fa, 16'h00f1, 16'h00d1, 16'h00aa, 16'h00ba,
        16'h00bf, 16'h2310, 16'h00ac, 16'h00bd, 16'h00bc, 16'h00a1, 16'h00ab, 16'h00bb,
        16'h2591, 16'h2592, 16'h2593, 16'h2502, 16'h2524, 16'h2561, 16'h2562, 16'h2556,
        16'h2555, 16'h2563, 16'h2551, 16'h2557, 16'h255d, 16'h255c, 16'h255b, 16'h2510,
        16'h2514, 16'h2534, 16'h252c, 16'h251c, 16'h2500, 16'h253c, 16'h255e, 16'h255f,
        16'h255a, 16'h2554, 16'h2569, 16'h2566, 16'h2560, 16'h2550, 16'h256c, 16'h2567,
        16'h2568, 16'h2564, 16'h2565, 16'h2559, 16'h2558, 16'h2552, 16'h2553, 16'h256b,
        16'h256a, 16'h2518, 16'h250c, 16'h2588, 16'h2584, 16'h258c, 16'h2590, 16'h2580,
        16'h03b1, 16'h00df, 16'h0393, 16'h03c0, 16'h03a3, 16'h03c3, 16'h00b5, 16'h03c4,
        16'h03a6, 16'h0398, 16'h03a9, 16'h03b4, 16'h221e, 16'h03c6, 16'h03b5, 16'h2229,
        16'h2261, 16'h00b1, 16'h2265, 16'h2264, 16'h2320, 16'h2321, 16'h00f7, 16'h2248,
        16'h00b0, 16'h2219, 16'h00b7, 16'h221a, 16'h207f, 16'h00b2, 16'h25a0, 16'h00a0
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [1:0]  cfg_data = 2'd0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [20:0] code_unit = 21'd0;
    logic        end_of_text = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  out_byte;
    logic        run_end;

    logic        run = 1'b0;
    logic        calm = 1'b0;
    int          err_cnt = 0;

    text_act_t   stim_q[$];
    byte_exp_t   byte_q[$];
    logic [7:0]  run_bytes[$];

    // encoder state as the bench sees it
    enc_t        enc_sel = ENC_UTF8;
    logic        join_pairs = 1'b1;
    logic        pend_high = 1'b0;
    logic [9:0]  pend_bits = 10'd0;

    code_point_to_byte_encoder_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .code_unit   (code_unit),
        .end_of_text (end_of_text),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .run_end     (run_end)
    );

    always #5 clk = ~clk;

    function automatic void put(input logic [31:0] w);
        run_bytes.push_back(w[7:0]);
    endfunction

    function automatic void encode_cp(input logic [31:0] cp);
        logic [31:0] v;
        logic [31:0] hi;
        logic [31:0] lo;
        logic [7:0]  hit;
        logic        found;
        v     = cp - 32'h10000;
        hi    = ((v >> 10) | 32'hd800) & 32'hffff;
        lo    = (v & 32'h3ff) | 32'hdc00;
        hit   = SUB_CHAR;
        found = 1'b0;
        case (enc_sel)
            ENC_ISO8859:
            begin
                put((cp <= 32'hff) ? cp : {24'd0, SUB_CHAR});
            end
            ENC_UTF8:
            begin
                if (cp < 32'h80)
                begin
                    put(cp);
                end
                else if (cp < 32'h800)
                begin
                    put((cp >> 6) | 32'hc0);
                    put((cp & 32'h3f) | 32'h80);
                end
                else if (cp < 32'h10000)
                begin
                    put((cp >> 12) | 32'he0);
                    put(((cp >> 6) & 32'h3f) | 32'h80);
                    put((cp & 32'h3f) | 32'h80);
                end
                else
                begin
                    put((cp >> 18) | 32'hf0);
                    put(((cp >> 12) & 32'h3f) | 32'h80);
                    put(((cp >> 6) & 32'h3f) | 32'h80);
                    put((cp & 32'h3f) | 32'h80);
                end
            end
            ENC_UTF16BE:
            begin
                if (cp < 32'h10000)
                begin
                    put(cp >> 8);
                    put(cp);
                end
                else
                begin
                    put(hi >> 8);
                    put(hi);
                    put(lo >> 8);
                    put(lo);
                end
            end
            default:
            begin
                if (cp < 32'h80)
                begin
                    put(cp);
                end
                else
                begin
                    if (cp < 32'h266b)
                    begin
                        for (int i = 0; i < 256; i++)
                        begin
                            if (!found && {16'd0, CP437_GLYPH[i]} == cp)
                            begin
                                hit   = i[7:0];
                                found = 1'b1;
                            end
                        end
                    end
                    put({24'd0, hit});
                end
            end
        endcase
    endfunction

    // expected bytes for one accepted code unit, queued in order
    function automatic void predict_bytes(input logic [20:0] cu, input logic eot);
        logic        fresh;
        logic [31:0] cu32;
        byte_exp_t   e;
        cu32  = {11'd0, cu};
        fresh = 1'b1;
        run_bytes.delete();
        if (pend_high)
        begin
            pend_high = 1'b0;
            if (cu32 >= 32'hdc00 && cu32 < 32'he000)
            begin
                encode_cp(32'h10000 + ({22'd0, pend_bits} << 10) + (cu32 - 32'hdc00));
                fresh = 1'b0;
            end
            else
            begin
                encode_cp(32'hd800 | {22'd0, pend_bits});
            end
        end
        if (fresh)
        begin
            if (join_pairs && !eot && cu32 >= 32'hd800 && cu32 < 32'hdc00)
            begin
                pend_bits = cu[9:0];
                pend_high = 1'b1;
            end
            else
            begin
                encode_cp(cu32);
            end
        end
        foreach (run_bytes[k])
        begin
            e.data = run_bytes[k];
            e.last = (k == run_bytes.size() - 1);
            byte_q.push_back(e);
        end
    endfunction

    // sender
    always @(posedge clk)
    begin : drive_proc
        logic nxt_valid;
        logic nxt_we;
        int   gap_left;
        int   quiet_cyc;
        nxt_valid = in_valid;
        nxt_we    = 1'b0;
        if (in_valid && !in_stall)
        begin
            predict_bytes(code_unit, end_of_text);
            nxt_valid = 1'b0;
        end
        if (in_valid || byte_q.size() != 0)
            quiet_cyc = 0;
        else
            quiet_cyc++;
        if (run && !nxt_valid)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
            end
            else if (stim_q.size() > 0)
            begin
                case (stim_q[0].kind)
                    ACT_UNIT:
                    begin
                        code_unit   <= stim_q[0].cu;
                        end_of_text <= stim_q[0].eot;
                        nxt_valid   = 1'b1;
                        gap_left    = calm ? 0 : $urandom_range(0, 16);
                        void'(stim_q.pop_front());
                    end
                    ACT_CFG:
                    begin
                        if (quiet_cyc >= SETTLE_CYC)
                        begin
                            cfg_index <= stim_q[0].reg_sel;
                            cfg_data  <= stim_q[0].reg_val;
                            nxt_we    = 1'b1;
                            if (stim_q[0].reg_sel == CFG_OUTPUT_ENCODING)
                                enc_sel = enc_t'(stim_q[0].reg_val);
                            else
                                join_pairs = stim_q[0].reg_val[0];
                            void'(stim_q.pop_front());
                        end
                    end
                    default:
                    begin
                        if (quiet_cyc >= SETTLE_CYC)
                        begin
                            calm = ($urandom_range(0, 3) == 0);
                            void'(stim_q.pop_front());
                        end
                    end
                endcase
            end
        end
        in_valid <= nxt_valid;
        cfg_we   <= nxt_we;
    end

    // receiver and checker
    always @(posedge clk)
    begin : check_proc
        byte_exp_t e;
        int        stall_left;
        if (rst_n && out_valid && !out_stall)
        begin
            if (byte_q.size() == 0)
            begin
                $display("%0t: unexpected byte, expected none, actual %02h run_end %0b",
                         $time, out_byte, run_end);
                err_cnt++;
            end
            else
            begin
                e = byte_q.pop_front();
                if (out_byte !== e.data)
                begin
                    $display("%0t: out_byte expected %02h actual %02h",
                             $time, e.data, out_byte);
                    err_cnt++;
                end
                if (run_end !== e.last)
                begin
                    $display("%0t: run_end expected %0b actual %0b", $time, e.last, run_end);
                    err_cnt++;
                end
            end
            stall_left = calm ? 0 : $urandom_range(0, 16);
        end
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!run || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
                idle = 0;
            else
                idle++;
        end
        $display("Verification failed");
        $finish;
    end

    task automatic push_unit(input logic [20:0] cu, input logic eot);
        text_act_t a;
        a.kind    = ACT_UNIT;
        a.cu      = cu;
        a.eot     = eot;
        a.reg_sel = CFG_OUTPUT_ENCODING;
        a.reg_val = 2'd0;
        stim_q.push_back(a);
    endtask

    task automatic push_cfg(input cfg_idx_t sel, input logic [1:0] val);
        text_act_t a;
        a.kind    = ACT_CFG;
        a.cu      = 21'd0;
        a.eot     = 1'b0;
        a.reg_sel = sel;
        a.reg_val = val;
        stim_q.push_back(a);
    endtask

    task automatic push_drain();
        text_act_t a;
        a.kind    = ACT_DRAIN;
        a.cu      = 21'd0;
        a.eot     = 1'b0;
        a.reg_sel = CFG_OUTPUT_ENCODING;
        a.reg_val = 2'd0;
        stim_q.push_back(a);
    endtask

    task automatic push_phase(input enc_t enc, input logic join_on);
        push_drain();
        push_cfg(CFG_OUTPUT_ENCODING, enc);
        push_cfg(CFG_COMBINE_SURROGATES, {1'b0, join_on});
    endtask

    // mostly well-formed text, some broken surrogate sequences and out-of-range points
    task automatic gen_text(input int n);
        int          cnt;
        logic [20:0] cu;
        logic        eot;
        cnt = 0;
        while (cnt < n)
        begin
            eot = ($urandom_range(0, 7) == 0);
            case ($urandom_range(0, 11))
                0, 1, 2: cu = 21'($urandom_range(0, 'h7f));
                3:       cu = 21'($urandom_range('h80, 'hff));
                4, 5:    cu = {5'd0, CP437_GLYPH[$urandom_range(0, 255)]};
                6:       cu = 21'($urandom_range('h100, 'hffff));
                7:       cu = 21'($urandom_range('h10000, 'h10ffff));
                8, 9:
                begin
                    push_unit(21'($urandom_range('hd800, 'hdbff)), 1'b0);
                    cnt++;
                    cu = 21'($urandom_range('hdc00, 'hdfff));
                end
                10:      cu = 21'($urandom_range('hd800, 'hdfff));
                default:
                begin
                    if ($urandom_range(0, 1) == 0)
                        cu = 21'($urandom_range('h110000, 'h1fffff));
                    else
                        cu = 21'($urandom_range(0, 'h10ffff));
                end
            endcase
            push_unit(cu, eot);
            cnt++;
        end
    endtask

    initial
    begin
        push_unit(21'h000000, 1'b0);
        push_unit(21'h00007f, 1'b0);
        push_unit(21'h000080, 1'b0);
        push_unit(21'h0007ff, 1'b0);
        push_unit(21'h000800, 1'b0);
        push_unit(21'h00ffff, 1'b0);
        push_unit(21'h010000, 1'b0);
        push_unit(21'h10ffff, 1'b1);
        push_unit(21'h1fffff, 1'b0);
        push_unit(21'h110000, 1'b0);
        push_unit(21'h00d800, 1'b0);
        push_unit(21'h00dc00, 1'b0);
        push_unit(21'h00dbff, 1'b0);
        push_unit(21'h00dfff, 1'b1);
        // high surrogate orphaned by a plain character
        push_unit(21'h00d812, 1'b0);
        push_unit(21'h000041, 1'b0);
        // high after high: first goes out alone, second joins
        push_unit(21'h00d800, 1'b0);
        push_unit(21'h00d801, 1'b0);
        push_unit(21'h00dc02, 1'b0);
        push_unit(21'h00dbff, 1'b1);
        push_unit(21'h00dc05, 1'b0);
        // orphaned surrogate plus a four-byte point
        push_unit(21'h00d800, 1'b0);
        push_unit(21'h10ffff, 1'b0);
        // held across a config change; still joins with combining off
        push_unit(21'h00d83d, 1'b0);
        push_phase(ENC_UTF16BE, 1'b0);
        push_unit(21'h00de00, 1'b0);
        push_unit(21'h00d800, 1'b0);
        gen_text(24);
        push_phase(ENC_ISO8859, 1'b1);
        gen_text(24);
        push_phase(ENC_CP437, 1'b0);
        gen_text(24);
        push_phase(ENC_UTF8, 1'b0);
        gen_text(24);
        push_phase(ENC_ISO8859, 1'b0);
        gen_text(24);
        push_phase(ENC_CP437, 1'b1);
        gen_text(24);
        push_phase(ENC_UTF16BE, 1'b1);
        gen_text(24);
        push_phase(ENC_UTF8, 1'b1);
        gen_text(24);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        run   <= 1'b1;

        while (stim_q.size() != 0 || in_valid || byte_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYC) @(posedge clk);

        if (byte_q.size() != 0)
        begin
            $display("%0t: %0d expected bytes never arrived, next %02h",
                     $time, byte_q.size(), byte_q[0].data);
            err_cnt++;
        end
        if (err_cnt == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
